// File: hw/rtl/q2e_pkg.sv
// Shared types, constants and the arctangent table for the quaternion to Euler angle converter.
package q2e_pkg;

  localparam int CordicIterationsDefault = 16;
  localparam int AtanTableLen = 24;
  localparam int ValW = 36;
  localparam int AngW = 33;
  localparam logic signed [AngW-1:0] Q30HalfPi = 33'sd1686629713;
  localparam logic signed [17:0] Q13Pi = 18'sd25736;
  localparam logic signed [17:0] Q13HalfPi = 18'sd12868;

  typedef logic signed [ValW-1:0] val_t;
  typedef logic signed [AngW-1:0] ang_t;

  // Arctangent table, Q30, rounded to nearest
  function automatic ang_t atan_q30(input logic [4:0] i);
    ang_t r;
    r = '0;
    unique case (i)
      5'd0: r = 33'sd843314857;
      5'd1: r = 33'sd497837829;
      5'd2: r = 33'sd263043837;
      5'd3: r = 33'sd133525159;
      5'd4: r = 33'sd67021687;
      5'd5: r = 33'sd33543516;
      5'd6: r = 33'sd16775851;
      5'd7: r = 33'sd8388437;
      5'd8: r = 33'sd4194283;
      5'd9: r = 33'sd2097149;
      5'd10: r = 33'sd1048576;
      5'd11: r = 33'sd524288;
      5'd12: r = 33'sd262144;
      5'd13: r = 33'sd131072;
      5'd14: r = 33'sd65536;
      5'd15: r = 33'sd32768;
      5'd16: r = 33'sd16384;
      5'd17: r = 33'sd8192;
      5'd18: r = 33'sd4096;
      5'd19: r = 33'sd2048;
      5'd20: r = 33'sd1024;
      5'd21: r = 33'sd512;
      5'd22: r = 33'sd256;
      5'd23: r = 33'sd128;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/quaternion_to_euler_angles.sv
// Top level: quaternion (Q1.15) to ZYX Euler angles (Q13 radians), fully pipelined.
// Accepts one word per cycle (busy is tied low) and returns each result exactly
// once, out_valid high for one cycle, after 2 product/sum stages, 1 stage that
// squares the pitch sine, 31 stages of integer square root for the pitch cosine,
// 1 pre-rotation stage, one CORDIC stage per iteration (CORDIC_ITERATIONS capped
// at 24) and 1 output stage. The
// receiver cannot stall; results must be taken when out_valid is high.
module quaternion_to_euler_angles #(
  parameter int CORDIC_ITERATIONS = q2e_pkg::CordicIterationsDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic signed [15:0] in_quat_w,
  output logic               out_valid,
  output logic signed [15:0] out_roll_angle,
  output logic signed [14:0] out_pitch_angle,
  output logic signed [15:0] out_yaw_angle,
  output logic               out_pitch_saturated
);

  localparam int SqrtSteps = 31;
  localparam int Steps = (CORDIC_ITERATIONS < q2e_pkg::AtanTableLen) ? CORDIC_ITERATIONS
                                                                      : q2e_pkg::AtanTableLen;
  localparam int AlignLen = SqrtSteps + 1;

  assign busy = 1'b0;

  // Stage 1: products
  logic signed [31:0] wx_r, yz_r, xx_r, yy_r, wz_r, xy_r, zz_r, wy_r, zx_r;
  logic               v1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= start;
    wx_r <= in_quat_w * in_quat_x;
    yz_r <= in_quat_y * in_quat_z;
    xx_r <= in_quat_x * in_quat_x;
    yy_r <= in_quat_y * in_quat_y;
    wz_r <= in_quat_w * in_quat_z;
    xy_r <= in_quat_x * in_quat_y;
    zz_r <= in_quat_z * in_quat_z;
    wy_r <= in_quat_w * in_quat_y;
    zx_r <= in_quat_z * in_quat_x;
  end

  // Stage 2: operand sums in Q30
  q2e_pkg::val_t ry_r, rx_r, yy2_r, yx_r, sinp_r;
  logic          v2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else v2_r <= v1_r;
    ry_r   <= 36'(2 * (36'(wx_r) + 36'(yz_r)));
    rx_r   <= 36'(36'sd1073741824 - 2 * (36'(xx_r) + 36'(yy_r)));
    yy2_r  <= 36'(2 * (36'(wz_r) + 36'(xy_r)));
    yx_r   <= 36'(36'sd1073741824 - 2 * (36'(yy_r) + 36'(zz_r)));
    sinp_r <= 36'(2 * (36'(wy_r) - 36'(zx_r)));
  end

  // Stage 3: pitch saturation check and 1.0 minus the square of |sinp| (Q60)
  logic [30:0] sabs_nxt;
  logic        sat_nxt;
  always_comb begin
    sat_nxt = (sinp_r >= 36'sd1073741824) || (sinp_r <= -36'sd1073741824);
    sabs_nxt = sinp_r[35] ? 31'(-sinp_r) : 31'(sinp_r);
  end

  logic [60:0] rem0_r;
  logic        v3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else v3_r <= v2_r;
    rem0_r <= 61'(62'd1 << 60) - (61'(sabs_nxt) * 61'(sabs_nxt));
  end

  // Integer square root, one result bit per stage
  logic [60:0] sq_n [SqrtSteps+1];
  logic [30:0] sq_r [SqrtSteps+1];
  assign sq_n[0] = rem0_r;
  assign sq_r[0] = '0;
  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    localparam int Sh = 60 - 2 * k;
    logic [61:0] trial;
    logic [60:0] n_q;
    logic [30:0] r_q;
    assign trial = 62'({sq_r[k], 31'd0} >> k) + 62'(62'd1 << Sh);
    always_ff @(posedge clk) begin
      n_q <= (62'(sq_n[k]) >= trial) ? 61'(62'(sq_n[k]) - trial) : sq_n[k];
      r_q <= (62'(sq_n[k]) >= trial) ? sq_r[k] | 31'(31'd1 << (30 - k)) : sq_r[k];
    end
    assign sq_n[k+1] = n_q;
    assign sq_r[k+1] = r_q;
  end

  // Align roll/yaw/pitch operands with the square root
  q2e_pkg::val_t ry_d [AlignLen], rx_d [AlignLen], yy_d [AlignLen], yx_d [AlignLen];
  q2e_pkg::val_t sp_d [AlignLen];
  logic          sat_d [AlignLen];
  logic          v_d [AlignLen];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < AlignLen; j++) v_d[j] <= 1'b0;
    end else begin
      v_d[0] <= v2_r;
      for (int j = 1; j < AlignLen; j++) v_d[j] <= v_d[j-1];
    end
    ry_d[0] <= ry_r; rx_d[0] <= rx_r; yy_d[0] <= yy2_r; yx_d[0] <= yx_r;
    sp_d[0] <= sinp_r; sat_d[0] <= sat_nxt;
    for (int j = 1; j < AlignLen; j++) begin
      ry_d[j] <= ry_d[j-1]; rx_d[j] <= rx_d[j-1];
      yy_d[j] <= yy_d[j-1]; yx_d[j] <= yx_d[j-1];
      sp_d[j] <= sp_d[j-1]; sat_d[j] <= sat_d[j-1];
    end
  end

  logic          vc;
  q2e_pkg::val_t cosp;
  assign vc = v_d[AlignLen-1];
  assign cosp = 36'(sq_r[SqrtSteps]);

  // Three CORDIC pipelines
  logic          rv, pv, yv;
  q2e_pkg::ang_t r_ang, p_ang, y_ang;
  q2e_cordic #(.Iterations(CORDIC_ITERATIONS)) u_roll (
    .clk, .rst_n, .in_valid(vc), .in_y(ry_d[AlignLen-1]), .in_x(rx_d[AlignLen-1]),
    .out_valid(rv), .out_angle(r_ang));
  q2e_cordic #(.Iterations(CORDIC_ITERATIONS)) u_yaw (
    .clk, .rst_n, .in_valid(vc), .in_y(yy_d[AlignLen-1]), .in_x(yx_d[AlignLen-1]),
    .out_valid(yv), .out_angle(y_ang));
  q2e_cordic #(.Iterations(CORDIC_ITERATIONS)) u_pitch (
    .clk, .rst_n, .in_valid(vc), .in_y(sp_d[AlignLen-1]), .in_x(cosp),
    .out_valid(pv), .out_angle(p_ang));

  // Carry the saturation flag and sign alongside the CORDIC
  logic sat_c [Steps+1];
  logic neg_c [Steps+1];
  always_ff @(posedge clk) begin
    sat_c[0] <= sat_d[AlignLen-1];
    neg_c[0] <= sp_d[AlignLen-1][35];
    for (int j = 1; j <= Steps; j++) begin
      sat_c[j] <= sat_c[j-1];
      neg_c[j] <= neg_c[j-1];
    end
  end

  // Q30 to Q13 with round half up and clamp
  function automatic logic signed [17:0] to_q13(input q2e_pkg::ang_t a,
                                                input logic signed [17:0] lim);
    logic signed [33:0] s;
    logic signed [17:0] r;
    s = 34'(a) + 34'sd65536;
    r = 18'(s >>> 17);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  logic signed [17:0] roll_q, yaw_q, pitch_q;
  always_comb begin
    roll_q = to_q13(r_ang, q2e_pkg::Q13Pi);
    yaw_q  = to_q13(y_ang, q2e_pkg::Q13Pi);
    if (sat_c[Steps]) pitch_q = neg_c[Steps] ? -q2e_pkg::Q13HalfPi : q2e_pkg::Q13HalfPi;
    else pitch_q = to_q13(p_ang, q2e_pkg::Q13HalfPi);
  end

  logic               out_valid_r;
  logic signed [15:0] roll_r, yaw_r;
  logic signed [14:0] pitch_r;
  logic               sat_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= rv;
    roll_r  <= 16'(roll_q);
    yaw_r   <= 16'(yaw_q);
    pitch_r <= 15'(pitch_q);
    sat_r   <= sat_c[Steps];
  end

  assign out_valid           = out_valid_r;
  assign out_roll_angle      = roll_r;
  assign out_pitch_angle     = pitch_r;
  assign out_yaw_angle       = yaw_r;
  assign out_pitch_saturated = sat_r;

`ifndef ASSERT_OFF
  a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
    rv == pv && rv == yv) else $error("CORDIC lanes out of step");
  a_sat_pitch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pitch_saturated |->
      (out_pitch_angle == 15'sd12868 || out_pitch_angle == -15'sd12868))
    else $error("saturated pitch not clamped");
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pitch_angle <= 15'sd12868 && out_pitch_angle >= -15'sd12868)
    else $error("pitch out of range");
  a_start_flows: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> v1_r) else $error("accepted word dropped");
`endif

endmodule

// File: hw/rtl/q2e_cordic.sv
// Pipelined CORDIC in vectoring mode: atan2(y, x) in Q30, one stage per step.
module q2e_cordic #(
  parameter int Iterations = q2e_pkg::CordicIterationsDefault
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  q2e_pkg::val_t   in_y,
  input  q2e_pkg::val_t   in_x,
  output logic            out_valid,
  output q2e_pkg::ang_t   out_angle
);

  localparam int Steps = (Iterations < q2e_pkg::AtanTableLen) ? Iterations
                                                             : q2e_pkg::AtanTableLen;

  q2e_pkg::val_t x_r [Steps+1];
  q2e_pkg::val_t y_r [Steps+1];
  q2e_pkg::ang_t z_r [Steps+1];
  logic          v_r [Steps+1];
  logic          zf_r [Steps+1];

  q2e_pkg::val_t x0_nxt, y0_nxt;
  q2e_pkg::ang_t z0_nxt;

  // Pre-rotation into the right half plane
  always_comb begin
    x0_nxt = in_x;
    y0_nxt = in_y;
    z0_nxt = '0;
    if (in_x < 0) begin
      if (in_y >= 0) begin
        x0_nxt = in_y;
        y0_nxt = -in_x;
        z0_nxt = q2e_pkg::Q30HalfPi;
      end else begin
        x0_nxt = -in_y;
        y0_nxt = in_x;
        z0_nxt = -q2e_pkg::Q30HalfPi;
      end
    end
  end

  // Both operands zero: flag travels along and forces a zero angle
  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else v_r[0] <= in_valid;
    x_r[0] <= x0_nxt;
    y_r[0] <= y0_nxt;
    z_r[0] <= z0_nxt;
    zf_r[0] <= (in_x == 0) && (in_y == 0);
  end

  // One micro-rotation per stage
  for (genvar i = 0; i < Steps; i++) begin : g_step
    q2e_pkg::val_t xs, ys;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[i+1] <= 1'b0;
      else v_r[i+1] <= v_r[i];
      zf_r[i+1] <= zf_r[i];
      if (y_r[i] >= 0) begin
        x_r[i+1] <= x_r[i] + ys;
        y_r[i+1] <= y_r[i] - xs;
        z_r[i+1] <= z_r[i] + q2e_pkg::atan_q30(5'(i));
      end else begin
        x_r[i+1] <= x_r[i] - ys;
        y_r[i+1] <= y_r[i] + xs;
        z_r[i+1] <= z_r[i] - q2e_pkg::atan_q30(5'(i));
      end
    end
  end

  assign out_valid = v_r[Steps];
  assign out_angle = zf_r[Steps] ? '0 : z_r[Steps];

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the quaternion to Euler angle converter.
`timescale 1ns / 100ps

module testbench;

  localparam int Iters = q2e_pkg::CordicIterationsDefault;
  localparam int Latency = 2 + 1 + 31 + 1 + Iters + 1;
  localparam longint Q30One = 64'sd1 << 30;
  localparam longint HalfPiQ30 = 64'sd1686629713;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic               sat;
  } euler_t;

  logic clk, rst_n, start, busy, out_valid, out_pitch_saturated;
  logic signed [15:0] in_quat_x, in_quat_y, in_quat_z, in_quat_w;
  logic signed [15:0] out_roll_angle, out_yaw_angle;
  logic signed [14:0] out_pitch_angle;

  euler_t angles_due[$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int sat_seen = 0;
  bit idle_enable = 1'b1;

  quaternion_to_euler_angles DUT (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor division by 2^s
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  // CORDIC vectoring-mode arctangent, Q30 operands and angle
  function automatic longint arctan2_q30(longint yv, longint xv);
    longint acc, tmp, xs, ys;
    acc = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      if (yv >= 0) begin
        tmp = xv; xv = yv; yv = -tmp; acc = HalfPiQ30;
      end else begin
        tmp = xv; xv = -yv; yv = tmp; acc = -HalfPiQ30;
      end
    end
    for (int i = 0; i < Iters && i < q2e_pkg::AtanTableLen; i++) begin
      xs = floor_shift(xv, i);
      ys = floor_shift(yv, i);
      if (yv >= 0) begin
        xv = xv + ys; yv = yv - xs; acc += longint'(q2e_pkg::atan_q30(5'(i)));
      end else begin
        xv = xv - ys; yv = yv + xs; acc -= longint'(q2e_pkg::atan_q30(5'(i)));
      end
    end
    return acc;
  endfunction

  function automatic longint round_q13(longint a, longint lim);
    longint r;
    r = floor_shift(a + (64'sd1 << 16), 17);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic euler_t predict_angles(logic signed [15:0] qx, logic signed [15:0] qy,
                                            logic signed [15:0] qz, logic signed [15:0] qw);
    euler_t e;
    longint x, y, z, w, sinp;
    longint unsigned mag, rem;
    x = qx; y = qy; z = qz; w = qw;
    e.roll = 16'(round_q13(arctan2_q30(2 * (w * x + y * z), Q30One - 2 * (x * x + y * y)),
                           25736));
    e.yaw = 16'(round_q13(arctan2_q30(2 * (w * z + x * y), Q30One - 2 * (y * y + z * z)),
                          25736));
    sinp = 2 * (w * y - z * x);
    if (sinp >= Q30One || sinp <= -Q30One) begin
      e.pitch = (sinp > 0) ? 15'sd12868 : -15'sd12868;
      e.sat = 1'b1;
    end else begin
      mag = (sinp < 0) ? -sinp : sinp;
      rem = (64'd1 << 60) - mag * mag;
      e.pitch = 15'(round_q13(arctan2_q30(sinp, longint'(int_sqrt(rem))), 12868));
      e.sat = 1'b0;
    end
    return e;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  // send one word; optional random idle cycles before it
  task automatic send_quat(logic signed [15:0] qx, logic signed [15:0] qy,
                           logic signed [15:0] qz, logic signed [15:0] qw);
    while (idle_enable && $urandom_range(99) < 20) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_quat_x <= qx; in_quat_y <= qy; in_quat_z <= qz; in_quat_w <= qw;
    @(posedge clk);
    while (busy) @(posedge clk);
    angles_due.push_back(predict_angles(qx, qy, qz, qw));
    words_sent++;
    @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    euler_t exp_e;
    if (rst_n && out_valid) begin
      if (angles_due.size() == 0) begin
        errors++;
        $display("ERROR %0t: unexpected result word", $time);
      end else begin
        exp_e = angles_due.pop_front();
        words_checked++;
        if (exp_e.sat) sat_seen++;
        if (out_roll_angle !== exp_e.roll) report_mismatch("roll", out_roll_angle, exp_e.roll);
        if (out_pitch_angle !== exp_e.pitch)
          report_mismatch("pitch", out_pitch_angle, exp_e.pitch);
        if (out_yaw_angle !== exp_e.yaw) report_mismatch("yaw", out_yaw_angle, exp_e.yaw);
        if (out_pitch_saturated !== exp_e.sat)
          report_mismatch("pitch_saturated", out_pitch_saturated, exp_e.sat);
      end
    end
  end

  // stop sending and wait until every expected word has come back
  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (angles_due.size() != 0) @(negedge clk);
  endtask

  // field extremes, identity, gimbal lock, zero operands, negative x operand
  task automatic test_directed();
    logic signed [15:0] ext[4];
    ext = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1};
    send_quat(0, 0, 0, 16'sd32767);
    send_quat(0, 0, 0, 0);
    send_quat(16'sd32767, 0, 0, 0);
    send_quat(0, 16'sd32767, 0, 0);
    send_quat(0, 0, 16'sd32767, 0);
    send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send_quat(0, 16'sd23170, 0, 16'sd23170);
    send_quat(0, -16'sd23170, 0, 16'sd23170);
    send_quat(16'sd23170, 0, -16'sd23170, 0);
    send_quat(16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384);
    send_quat(16'sd1, 16'sd0, 16'sd0, -16'sd1);
    for (int i = 0; i < 4; i++)
      send_quat(ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4], ext[(i + 3) % 4]);
    send_quat(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
  endtask

  // random words: mostly near-unit quaternions, some raw bit patterns
  task automatic test_random(int count);
    logic signed [15:0] q[4];
    int s;
    for (int n = 0; n < count; n++) begin
      idle_enable = !(n >= 300 && n < 450);
      if ($urandom_range(99) < 30) begin
        foreach (q[k]) q[k] = 16'($urandom);
      end else begin
        // random direction scaled so the norm lands near one
        foreach (q[k]) q[k] = 16'($signed(14'($urandom)));
        s = 0;
        foreach (q[k]) s += q[k] * q[k];
        if (s > 0)
          foreach (q[k]) q[k] = 16'(longint'(q[k]) * 32700 / int'($sqrt(real'(s))));
      end
      send_quat(q[0], q[1], q[2], q[3]);
      if (n == 500) drain_results();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_quat_x = 0; in_quat_y = 0; in_quat_z = 0; in_quat_w = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    drain_results();
    test_random(800);
    drain_results();
    repeat (Latency + 10) @(posedge clk);
    $display("Checked %0d of %0d words, %0d with pitch clamped.",
             words_checked, words_sent, sat_seen);
    $display("Covered field extremes, gimbal lock, zero and negative-x atan2 cases.");
    if (errors == 0 && angles_due.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: quaternion_to_euler_angles.f
hw/rtl/q2e_pkg.sv
hw/rtl/q2e_cordic.sv
hw/rtl/quaternion_to_euler_angles.sv
dv/testbench.sv
